// File: sv/frb_pkg.sv
// ----------------------------------------------------------------------------
// Feathered rectangle blend package
// Shared widths, register indexes, blend modes and the structures that pass
// between the classification, ratio and blend stages.
// ----------------------------------------------------------------------------
package frb_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned DIST_W    = DATA_W + 1;
  localparam int unsigned RATIO_W   = FRAC_W + 1;
  localparam int unsigned REG_IDX_W = 3;

  localparam logic [RATIO_W-1:0] ONE_Q = {1'b1, {FRAC_W{1'b0}}};

  typedef enum logic [REG_IDX_W-1:0] {
    REG_OUTER_X_LOW  = 3'd0,
    REG_INNER_X_LOW  = 3'd1,
    REG_INNER_X_HIGH = 3'd2,
    REG_OUTER_X_HIGH = 3'd3,
    REG_OUTER_Y_LOW  = 3'd4,
    REG_INNER_Y_LOW  = 3'd5,
    REG_INNER_Y_HIGH = 3'd6,
    REG_OUTER_Y_HIGH = 3'd7
  } reg_idx_t;

  typedef enum logic [2:0] {
    MODE_MAIN,
    MODE_ADDED,
    MODE_X,
    MODE_Y,
    MODE_CORNER
  } mode_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] outer_x_low;
    logic signed [DATA_W-1:0] inner_x_low;
    logic signed [DATA_W-1:0] inner_x_high;
    logic signed [DATA_W-1:0] outer_x_high;
    logic signed [DATA_W-1:0] outer_y_low;
    logic signed [DATA_W-1:0] inner_y_low;
    logic signed [DATA_W-1:0] inner_y_high;
    logic signed [DATA_W-1:0] outer_y_high;
  } bounds_t;

  typedef struct packed {
    mode_t                    mode;
    logic signed [DATA_W-1:0] main_value;
    logic signed [DATA_W-1:0] added_value;
    logic signed [DIST_W-1:0] diff;
  } side_t;

  typedef struct packed {
    logic [DIST_W-1:0] an;
    logic [DIST_W-1:0] ad;
    logic              one;
    logic              zero;
  } dist_t;

endpackage

// File: sv/frb_zone.sv
// ----------------------------------------------------------------------------
// Feathered rectangle blend zone stages
// Classifies the point against both rectangles, forms the band distances and
// reduces them to magnitudes with their special cases, over three stages.
// ----------------------------------------------------------------------------
module frb_zone (
  input  logic                             clk,
  input  logic                             rst,
  input  frb_pkg::bounds_t                 bounds,
  input  logic                             in_valid,
  input  logic signed [frb_pkg::DATA_W-1:0] coord_x,
  input  logic signed [frb_pkg::DATA_W-1:0] coord_y,
  input  logic signed [frb_pkg::DATA_W-1:0] main_value,
  input  logic signed [frb_pkg::DATA_W-1:0] added_value,
  output logic                             out_valid,
  output frb_pkg::dist_t                   x_dist,
  output frb_pkg::dist_t                   y_dist,
  output frb_pkg::side_t                   side
);
  import frb_pkg::*;

  logic                     v1;
  logic                     v2;
  logic signed [DATA_W-1:0] x1;
  logic signed [DATA_W-1:0] y1;
  logic signed [DATA_W-1:0] m1;
  logic signed [DATA_W-1:0] a1;
  logic                     hi_x1;
  logic                     hi_y1;
  mode_t                    mode1;
  mode_t                    mode_next;
  logic                     outside;
  logic                     in_x;
  logic                     in_y;
  logic signed [DIST_W-1:0] num_x2;
  logic signed [DIST_W-1:0] den_x2;
  logic signed [DIST_W-1:0] num_y2;
  logic signed [DIST_W-1:0] den_y2;
  side_t                    side2;

  function automatic dist_t make_dist(input logic signed [DIST_W-1:0] num,
                                      input logic signed [DIST_W-1:0] den);
    dist_t d;
    d.one  = (den == '0);
    d.zero = !d.one && ((num == '0) || (num[DIST_W-1] != den[DIST_W-1]));
    d.an   = num[DIST_W-1] ? DIST_W'(-num) : num;
    d.ad   = den[DIST_W-1] ? DIST_W'(-den) : den;
    return d;
  endfunction

  always_comb begin
    outside = (coord_x < bounds.outer_x_low) || (coord_x > bounds.outer_x_high) ||
              (coord_y < bounds.outer_y_low) || (coord_y > bounds.outer_y_high);
    in_x    = (coord_x >= bounds.inner_x_low) && (coord_x <= bounds.inner_x_high);
    in_y    = (coord_y >= bounds.inner_y_low) && (coord_y <= bounds.inner_y_high);
    if (outside) begin
      mode_next = MODE_MAIN;
    end else if (in_x && in_y) begin
      mode_next = MODE_ADDED;
    end else if (in_x) begin
      mode_next = MODE_Y;
    end else if (in_y) begin
      mode_next = MODE_X;
    end else begin
      mode_next = MODE_CORNER;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end

    x1    <= coord_x;
    y1    <= coord_y;
    m1    <= main_value;
    a1    <= added_value;
    mode1 <= mode_next;
    hi_x1 <= coord_x > bounds.inner_x_high;
    hi_y1 <= coord_y > bounds.inner_y_high;

    num_x2 <= hi_x1 ? DIST_W'(x1) - DIST_W'(bounds.inner_x_high)
                    : DIST_W'(bounds.inner_x_low) - DIST_W'(x1);
    den_x2 <= hi_x1 ? DIST_W'(bounds.outer_x_high) - DIST_W'(bounds.inner_x_high)
                    : DIST_W'(bounds.inner_x_low) - DIST_W'(bounds.outer_x_low);
    num_y2 <= hi_y1 ? DIST_W'(y1) - DIST_W'(bounds.inner_y_high)
                    : DIST_W'(bounds.inner_y_low) - DIST_W'(y1);
    den_y2 <= hi_y1 ? DIST_W'(bounds.outer_y_high) - DIST_W'(bounds.inner_y_high)
                    : DIST_W'(bounds.inner_y_low) - DIST_W'(bounds.outer_y_low);
    side2.mode        <= mode1;
    side2.main_value  <= m1;
    side2.added_value <= a1;
    side2.diff        <= DIST_W'(a1) - DIST_W'(m1);

    x_dist <= make_dist(num_x2, den_x2);
    y_dist <= make_dist(num_y2, den_y2);
    side   <= side2;
  end

endmodule

// File: sv/frb_ratio.sv
// ----------------------------------------------------------------------------
// Feathered rectangle blend ratio pipeline
// Restoring division of both band distances, one quotient bit per stage,
// giving saturated Q1.16 ratios for the x and y axes.
// ----------------------------------------------------------------------------
module frb_ratio (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  frb_pkg::dist_t                x_dist,
  input  frb_pkg::dist_t                y_dist,
  input  frb_pkg::side_t                side_in,
  output logic                          out_valid,
  output logic [frb_pkg::RATIO_W-1:0]   ratio_x,
  output logic [frb_pkg::RATIO_W-1:0]   ratio_y,
  output frb_pkg::side_t                side_out
);
  import frb_pkg::*;

  typedef struct packed {
    logic [DIST_W-1:0] rem;
    logic [DIST_W-1:0] ad;
    logic [FRAC_W-1:0] q;
    logic              one;
    logic              zero;
    logic              sat;
  } div_t;

  logic [FRAC_W:0] vld;
  div_t            xs    [0:FRAC_W];
  div_t            ys    [0:FRAC_W];
  side_t           sides [0:FRAC_W];

  function automatic div_t div_load(input dist_t d);
    div_t s;
    s.rem  = d.an;
    s.ad   = d.ad;
    s.q    = '0;
    s.one  = d.one;
    s.zero = d.zero;
    s.sat  = d.an >= d.ad;
    return s;
  endfunction

  function automatic div_t div_step(input div_t s);
    logic [DIST_W:0] t;
    logic [DIST_W:0] d;
    div_t            n;
    n = s;
    t = {s.rem, 1'b0};
    d = {1'b0, s.ad};
    if (t >= d) begin
      n.rem = DIST_W'(t - d);
      n.q   = {s.q[FRAC_W-2:0], 1'b1};
    end else begin
      n.rem = DIST_W'(t);
      n.q   = {s.q[FRAC_W-2:0], 1'b0};
    end
    return n;
  endfunction

  function automatic logic [RATIO_W-1:0] div_result(input div_t s);
    logic [RATIO_W-1:0] r;
    if (s.one) begin
      r = ONE_Q;
    end else if (s.zero) begin
      r = '0;
    end else if (s.sat) begin
      r = ONE_Q;
    end else begin
      r = {1'b0, s.q};
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else begin
      vld       <= {vld[FRAC_W-1:0], in_valid};
      out_valid <= vld[FRAC_W];
    end

    xs[0]    <= div_load(x_dist);
    ys[0]    <= div_load(y_dist);
    sides[0] <= side_in;
    for (int k = 0; k < FRAC_W; k++) begin
      xs[k+1]    <= div_step(xs[k]);
      ys[k+1]    <= div_step(ys[k]);
      sides[k+1] <= sides[k];
    end

    ratio_x  <= div_result(xs[FRAC_W]);
    ratio_y  <= div_result(ys[FRAC_W]);
    side_out <= sides[FRAC_W];
  end

endmodule

// File: sv/frb_blend.sv
// ----------------------------------------------------------------------------
// Feathered rectangle blend mixing stages
// Picks the ratio for the zone, forms alpha, multiplies it into the source
// difference and adds the rounded product back as a saturated Q16.16 value.
// ----------------------------------------------------------------------------
module frb_blend (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic [frb_pkg::RATIO_W-1:0]       ratio_x,
  input  logic [frb_pkg::RATIO_W-1:0]       ratio_y,
  input  frb_pkg::side_t                    side,
  output logic                              out_valid,
  output logic signed [frb_pkg::DATA_W-1:0] blended_value
);
  import frb_pkg::*;

  localparam int unsigned PROD_W = RATIO_W + 1 + DIST_W;
  localparam int unsigned SUM_W  = PROD_W - FRAC_W;
  localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) <<< (FRAC_W - 1);
  localparam logic signed [DATA_W-1:0] MAX_VAL = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] MIN_VAL = {1'b1, {(DATA_W-1){1'b0}}};

  logic                     v1;
  logic                     v2;
  logic [RATIO_W-1:0]       r_sel;
  logic [RATIO_W-1:0]       alpha1;
  side_t                    side1;
  side_t                    side2;
  logic signed [PROD_W-1:0] prod2;
  logic signed [PROD_W-1:0] rounded;
  logic signed [SUM_W-1:0]  sum;
  logic signed [DATA_W-1:0] mixed;
  logic signed [DATA_W-1:0] result_next;

  always_comb begin
    case (side.mode) inside
      MODE_X:              r_sel = ratio_x;
      MODE_Y:              r_sel = ratio_y;
      MODE_CORNER:         r_sel = (ratio_y > ratio_x) ? ratio_y : ratio_x;
      MODE_MAIN, MODE_ADDED: r_sel = '0;
      default:             r_sel = '0;
    endcase
  end

  always_comb begin
    rounded = prod2 + HALF;
    sum     = SUM_W'(side2.main_value) + $signed(rounded[PROD_W-1:FRAC_W]);
    if (sum[SUM_W-1:DATA_W-1] == '0 || sum[SUM_W-1:DATA_W-1] == '1) begin
      mixed = sum[DATA_W-1:0];
    end else if (sum[SUM_W-1]) begin
      mixed = MIN_VAL;
    end else begin
      mixed = MAX_VAL;
    end
    case (side2.mode) inside
      MODE_MAIN:                  result_next = side2.main_value;
      MODE_ADDED:                 result_next = side2.added_value;
      MODE_X, MODE_Y, MODE_CORNER: result_next = mixed;
      default:                    result_next = side2.main_value;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end

    alpha1        <= ONE_Q - r_sel;
    side1         <= side;
    prod2         <= $signed({1'b0, alpha1}) * side1.diff;
    side2         <= side1;
    blended_value <= result_next;
  end

endmodule

// File: sv/feathered_rectangle_blend.sv
// ----------------------------------------------------------------------------
// Feathered rectangle blend
// Blends a main and an added value over a rectangle with a soft border.
// ----------------------------------------------------------------------------
// The block takes one request in every clock cycle. It presents each result
// once the request has passed the zone, ratio and blend stages, with done
// high for exactly one cycle. Results leave in request order and cannot be
// held off, so the receiver must take each one in the cycle it appears.
// Nothing in the pipeline can stall, and busy is high only
// while reset is applied. The latency is set mostly by the ratio divider,
// which has a load stage, 16 stages that each produce one quotient bit, and
// a result stage. Three stages of zone classification come before it and
// three stages of blending come after it. The eight bound registers are read
// directly by the pipeline and should be written only while no request is
// in flight.
module feathered_rectangle_blend (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              wr_en,
  input  logic [frb_pkg::REG_IDX_W-1:0]     wr_index,
  input  logic [frb_pkg::DATA_W-1:0]        wr_data,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [frb_pkg::DATA_W-1:0] coord_x,
  input  logic signed [frb_pkg::DATA_W-1:0] coord_y,
  input  logic signed [frb_pkg::DATA_W-1:0] main_value,
  input  logic signed [frb_pkg::DATA_W-1:0] added_value,
  output logic                              done,
  output logic signed [frb_pkg::DATA_W-1:0] blended_value
);
  import frb_pkg::*;

  bounds_t            bounds;
  logic               request;
  logic               z_valid;
  dist_t              z_x;
  dist_t              z_y;
  side_t              z_side;
  logic               r_valid;
  logic [RATIO_W-1:0] r_x;
  logic [RATIO_W-1:0] r_y;
  side_t              r_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      bounds <= '0;
    end else if (wr_en) begin
      unique case (reg_idx_t'(wr_index))
        REG_OUTER_X_LOW:  bounds.outer_x_low  <= wr_data;
        REG_INNER_X_LOW:  bounds.inner_x_low  <= wr_data;
        REG_INNER_X_HIGH: bounds.inner_x_high <= wr_data;
        REG_OUTER_X_HIGH: bounds.outer_x_high <= wr_data;
        REG_OUTER_Y_LOW:  bounds.outer_y_low  <= wr_data;
        REG_INNER_Y_LOW:  bounds.inner_y_low  <= wr_data;
        REG_INNER_Y_HIGH: bounds.inner_y_high <= wr_data;
        REG_OUTER_Y_HIGH: bounds.outer_y_high <= wr_data;
      endcase
    end
  end

  assign busy    = rst;
  assign request = start && !busy;

  frb_zone u_zone (
    .clk         (clk),
    .rst         (rst),
    .bounds      (bounds),
    .in_valid    (request),
    .coord_x     (coord_x),
    .coord_y     (coord_y),
    .main_value  (main_value),
    .added_value (added_value),
    .out_valid   (z_valid),
    .x_dist      (z_x),
    .y_dist      (z_y),
    .side        (z_side)
  );

  frb_ratio u_ratio (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (z_valid),
    .x_dist    (z_x),
    .y_dist    (z_y),
    .side_in   (z_side),
    .out_valid (r_valid),
    .ratio_x   (r_x),
    .ratio_y   (r_y),
    .side_out  (r_side)
  );

  frb_blend u_blend (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (r_valid),
    .ratio_x       (r_x),
    .ratio_y       (r_y),
    .side          (r_side),
    .out_valid     (done),
    .blended_value (blended_value)
  );

endmodule

// File: sv/frb_checker.sv
// ----------------------------------------------------------------------------
// Feathered rectangle blend checker
// Port-level checks on request to result timing and on the result range.
// ----------------------------------------------------------------------------
module frb_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              start,
  input logic                              busy,
  input logic                              done,
  input logic signed [frb_pkg::DATA_W-1:0] main_value,
  input logic signed [frb_pkg::DATA_W-1:0] added_value,
  input logic signed [frb_pkg::DATA_W-1:0] blended_value
);
  import frb_pkg::*;

  localparam int unsigned LAT = 24;

  logic [4:0] quiet;

  always_ff @(posedge clk) begin
    if (rst) begin
      quiet <= '0;
    end else if (quiet != '1) begin
      quiet <= quiet + 5'd1;
    end
  end

  a_no_done_after_reset: assert property (@(posedge clk) rst |=> !done)
    else $error("Result strobe seen right after reset.");

  a_done_has_request: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("Result strobe without a matching request.");

  a_request_gives_done: assert property (@(posedge clk) disable iff (rst)
    (quiet >= 5'(LAT - 1) && $past(start && !busy, LAT)) |-> done)
    else $error("Request did not produce a result.");

  a_result_in_range: assert property (@(posedge clk) disable iff (rst)
    done |-> ((blended_value >= $past(main_value, LAT) &&
               blended_value <= $past(added_value, LAT)) ||
              (blended_value <= $past(main_value, LAT) &&
               blended_value >= $past(added_value, LAT))))
    else $error("Result lies outside the span of its two sources.");

endmodule

bind feathered_rectangle_blend frb_checker u_frb_checker (.*);

// File: sim/feathered_rectangle_blend_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Feathered rectangle blend testbench
// Drives points and source values into the blend block. It first sends a
// short directed set: extreme values, every zone and band, inverted
// rectangles and zero-width bands. It then runs phases of random points
// under random rectangle settings, with random gaps or in bursts. A
// scoreboard predicts each blended value from its own copy of the bound
// registers and compares it with the result stream in request order.
// ----------------------------------------------------------------------------
module feathered_rectangle_blend_tb;
  import frb_pkg::*;

  localparam logic signed [DATA_W-1:0] VMAX = 32'sh7fffffff;
  localparam logic signed [DATA_W-1:0] VMIN = 32'sh80000000;

  class blend_scoreboard;
    logic signed [DATA_W-1:0] bound [8];
    logic signed [DATA_W-1:0] expected_blend [$];
    int errors;

    function new();
      foreach (bound[i]) bound[i] = '0;
      errors = 0;
    endfunction

    function void set_bound(reg_idx_t idx, logic [DATA_W-1:0] v);
      bound[idx] = v;
    endfunction

    function int pending();
      return expected_blend.size();
    endfunction

    function longint band_ratio(longint num, longint den);
      longint unsigned an, ad, q;
      if (den == 0) return longint'(ONE_Q);
      if (num == 0) return 0;
      if ((num < 0) != (den < 0)) return 0;
      an = (num < 0) ? -num : num;
      ad = (den < 0) ? -den : den;
      q = (an << FRAC_W) / ad;
      return (q > longint'(ONE_Q)) ? longint'(ONE_Q) : longint'(q);
    endfunction

    function longint axis_fraction(longint c, longint olo, longint ilo, longint ihi,
                                   longint ohi);
      if (c <= ihi) return band_ratio(ilo - c, ilo - olo);
      return band_ratio(c - ihi, ohi - ihi);
    endfunction

    function logic signed [DATA_W-1:0] predict_blend(logic signed [DATA_W-1:0] px, py,
                                                     pm, pa);
      longint x, y, m, a, oxl, ixl, ixh, oxh, oyl, iyl, iyh, oyh;
      longint r, rx, ry, prod, res;
      bit in_x, in_y;
      x = px;
      y = py;
      m = pm;
      a = pa;
      oxl = bound[REG_OUTER_X_LOW];
      ixl = bound[REG_INNER_X_LOW];
      ixh = bound[REG_INNER_X_HIGH];
      oxh = bound[REG_OUTER_X_HIGH];
      oyl = bound[REG_OUTER_Y_LOW];
      iyl = bound[REG_INNER_Y_LOW];
      iyh = bound[REG_INNER_Y_HIGH];
      oyh = bound[REG_OUTER_Y_HIGH];
      if (x < oxl || x > oxh || y < oyl || y > oyh) return pm;
      in_x = (x >= ixl) && (x <= ixh);
      in_y = (y >= iyl) && (y <= iyh);
      if (in_x && in_y) return pa;
      if (in_x) begin
        r = axis_fraction(y, oyl, iyl, iyh, oyh);
      end else if (in_y) begin
        r = axis_fraction(x, oxl, ixl, ixh, oxh);
      end else begin
        rx = axis_fraction(x, oxl, ixl, ixh, oxh);
        ry = axis_fraction(y, oyl, iyl, iyh, oyh);
        r = (ry > rx) ? ry : rx;
      end
      prod = (longint'(ONE_Q) - r) * (a - m);
      res = m + ((prod + 32768) >>> FRAC_W);
      if (res > longint'(VMAX)) res = VMAX;
      if (res < longint'(VMIN)) res = VMIN;
      return res[DATA_W-1:0];
    endfunction

    function void note_request(logic signed [DATA_W-1:0] px, py, pm, pa);
      expected_blend.push_back(predict_blend(px, py, pm, pa));
    endfunction

    task report(string what);
      errors++;
      if (errors <= 40) $display("%0t mismatch: %s", $time, what);
    endtask

    task check_result(logic signed [DATA_W-1:0] got);
      logic signed [DATA_W-1:0] want;
      if (expected_blend.size() == 0) begin
        report($sformatf("blended_value %h with no request pending", got));
        return;
      end
      want = expected_blend.pop_front();
      if (got !== want)
        report($sformatf("blended_value got %h (%0d) expected %h (%0d)", got, got,
                         want, want));
    endtask

    task check_leftover();
      while (expected_blend.size() != 0) begin
        report($sformatf("blended_value %h never arrived", expected_blend.pop_front()));
      end
    endtask
  endclass

  logic                     clk;
  logic                     rst;
  logic                     wr_en;
  logic [REG_IDX_W-1:0]     wr_index;
  logic [DATA_W-1:0]        wr_data;
  logic                     start;
  logic                     busy;
  logic signed [DATA_W-1:0] coord_x;
  logic signed [DATA_W-1:0] coord_y;
  logic signed [DATA_W-1:0] main_value;
  logic signed [DATA_W-1:0] added_value;
  logic                     done;
  logic signed [DATA_W-1:0] blended_value;

  logic signed [DATA_W-1:0] rect_setting [8];
  blend_scoreboard sb = new();

  feathered_rectangle_blend DUT (
    .clk(clk),
    .rst(rst),
    .wr_en(wr_en),
    .wr_index(wr_index),
    .wr_data(wr_data),
    .start(start),
    .busy(busy),
    .coord_x(coord_x),
    .coord_y(coord_y),
    .main_value(main_value),
    .added_value(added_value),
    .done(done),
    .blended_value(blended_value)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.check_result(blended_value);
      if (wr_en) sb.set_bound(reg_idx_t'(wr_index), wr_data);
      if (start && !busy) sb.note_request(coord_x, coord_y, main_value, added_value);
    end
  end

  function automatic logic signed [DATA_W-1:0] q16(int n);
    return n <<< FRAC_W;
  endfunction

  function automatic int pick_gap(bit burst);
    int k;
    k = $urandom_range(0, 99);
    if (burst || k < 60) return 0;
    if (k < 88) return $urandom_range(1, 3);
    if (k < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value();
    int k;
    k = $urandom_range(0, 99);
    if (k < 70) return $urandom;
    if (k < 80) return $urandom_range(0, 1) ? VMAX : VMIN;
    return int'($urandom_range(0, 1 << 20)) - (1 << 19);
  endfunction

  function automatic void gen_axis(output logic signed [DATA_W-1:0] olo, ilo, ihi, ohi);
    longint v [4];
    longint t;
    int kind, i, j;
    kind = $urandom_range(0, 9);
    v[0] = longint'(int'($urandom_range(0, 1 << 25))) - (1 << 24);
    for (i = 1; i < 4; i++) v[i] = v[i-1] + $urandom_range(1, 1 << 20);
    case (kind)
      0: begin
        for (i = 0; i < 4; i++) v[i] = longint'(int'($urandom));
        for (i = 0; i < 3; i++)
          for (j = 0; j < 3 - i; j++)
            if (v[j] > v[j+1]) begin
              t = v[j];
              v[j] = v[j+1];
              v[j+1] = t;
            end
      end
      1: begin
        i = $urandom_range(0, 3);
        j = $urandom_range(0, 3);
        t = v[i];
        v[i] = v[j];
        v[j] = t;
      end
      2: begin
        if ($urandom_range(0, 1)) v[1] = v[0];
        else v[2] = v[3];
      end
      3: begin
        v[0] = VMIN;
        v[3] = VMAX;
      end
      default: ;
    endcase
    olo = v[0][DATA_W-1:0];
    ilo = v[1][DATA_W-1:0];
    ihi = v[2][DATA_W-1:0];
    ohi = v[3][DATA_W-1:0];
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_coord(logic signed [DATA_W-1:0] olo,
                                                          ilo, ihi, ohi);
    longint lo, hi, span;
    longint unsigned draw;
    logic signed [DATA_W-1:0] e;
    int k;
    k = $urandom_range(0, 99);
    if (k < 10) return $urandom;
    if (k < 35) begin
      case ($urandom_range(0, 3))
        0: e = olo;
        1: e = ilo;
        2: e = ihi;
        default: e = ohi;
      endcase
      return e + (int'($urandom_range(0, 6)) - 3);
    end
    lo = (olo < ohi) ? olo : ohi;
    hi = (olo < ohi) ? ohi : olo;
    span = hi - lo;
    draw = {$urandom, $urandom};
    return DATA_W'(lo + longint'(draw % longint'(span + 1)));
  endfunction

  task automatic idle_for(int n);
    if (n == 0) return;
    start = 1'b0;
    coord_x = $urandom;
    coord_y = $urandom;
    main_value = $urandom;
    added_value = $urandom;
    repeat (n) @(negedge clk);
  endtask

  task automatic send_point(logic signed [DATA_W-1:0] x, y, m, a);
    start = 1'b1;
    coord_x = x;
    coord_y = y;
    main_value = m;
    added_value = a;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drain();
    start = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic load_bounds();
    for (int i = 0; i < 8; i++) begin
      wr_en = 1'b1;
      wr_index = reg_idx_t'(i);
      wr_data = rect_setting[i];
      @(negedge clk);
    end
    wr_en = 1'b0;
  endtask

  initial begin
    bit burst;
    rst = 1'b1;
    wr_en = 1'b0;
    wr_index = '0;
    wr_data = '0;
    start = 1'b0;
    coord_x = '0;
    coord_y = '0;
    main_value = '0;
    added_value = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_point(0, 0, q16(3), q16(-7));
    send_point(1, 0, q16(3), q16(-7));
    send_point(VMIN, VMAX, VMAX, VMIN);
    wait_drain();

    rect_setting = '{q16(-10), q16(-5), q16(5), q16(10), q16(-8), q16(-4), q16(4), q16(8)};
    load_bounds();
    send_point(0, 0, VMIN, VMAX);
    send_point(-32'sd491520, 0, q16(100), q16(-100));
    send_point(q16(8), q16(1), VMAX, VMIN);
    send_point(q16(1), q16(-6), q16(-50), q16(50));
    send_point(q16(7) + 12345, q16(-2), q16(1), q16(2));
    send_point(q16(-9), q16(6), q16(20), q16(-20));
    send_point(q16(7), q16(-7), VMIN, VMAX);
    send_point(q16(5), q16(4), q16(9), q16(-9));
    send_point(q16(-10), 0, q16(9), q16(-9));
    send_point(q16(10) + 1, 0, q16(9), q16(-9));
    idle_for(3);
    send_point(q16(-6), q16(3), VMIN, VMAX);
    wait_drain();

    rect_setting = '{VMIN, q16(-1), q16(1), VMAX, VMIN, q16(-1), q16(1), VMAX};
    load_bounds();
    send_point(VMIN, 0, VMAX, VMIN);
    send_point(VMAX, VMAX, VMIN, VMAX);
    send_point(q16(-100), q16(30000), VMAX, VMIN);
    wait_drain();

    rect_setting = '{0, q16(4), q16(2), q16(6), q16(-3), q16(-3), q16(3), q16(3)};
    load_bounds();
    send_point(q16(3), 0, q16(10), q16(-10));
    send_point(q16(1), q16(-3), q16(-4), q16(12));
    send_point(q16(5), q16(3), VMAX, VMIN);
    wait_drain();

    rect_setting = '{q16(5), q16(-1), q16(1), q16(-5), q16(5), q16(-1), q16(1), q16(-5)};
    load_bounds();
    send_point(0, 0, q16(7), q16(-7));
    send_point(q16(5), q16(5), VMIN, VMAX);
    wait_drain();

    for (int phase = 0; phase < 11; phase++) begin
      gen_axis(rect_setting[REG_OUTER_X_LOW], rect_setting[REG_INNER_X_LOW],
               rect_setting[REG_INNER_X_HIGH], rect_setting[REG_OUTER_X_HIGH]);
      gen_axis(rect_setting[REG_OUTER_Y_LOW], rect_setting[REG_INNER_Y_LOW],
               rect_setting[REG_INNER_Y_HIGH], rect_setting[REG_OUTER_Y_HIGH]);
      load_bounds();
      burst = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < 100; n++) begin
        idle_for(pick_gap(burst));
        send_point(pick_coord(rect_setting[REG_OUTER_X_LOW], rect_setting[REG_INNER_X_LOW],
                              rect_setting[REG_INNER_X_HIGH],
                              rect_setting[REG_OUTER_X_HIGH]),
                   pick_coord(rect_setting[REG_OUTER_Y_LOW], rect_setting[REG_INNER_Y_LOW],
                              rect_setting[REG_INNER_Y_HIGH],
                              rect_setting[REG_OUTER_Y_HIGH]),
                   pick_value(), pick_value());
      end
      wait_drain();
    end

    repeat (30) @(posedge clk);
    sb.check_leftover();
    if (sb.errors == 0) begin
      $display("[feathered_rectangle_blend] OK");
    end else begin
      $display("[feathered_rectangle_blend] ERROR");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("[feathered_rectangle_blend] ERROR");
    $finish;
  end

endmodule

// File: files.f
sv/frb_pkg.sv
sv/frb_zone.sv
sv/frb_ratio.sv
sv/frb_blend.sv
sv/feathered_rectangle_blend.sv
sv/frb_checker.sv
sim/feathered_rectangle_blend_tb.sv
